// ===== sv/touch_burst_qualifier_assert.svh =====
// assertion macros for the touch burst qualifier
`ifndef TOUCH_BURST_QUALIFIER_ASSERT_SVH
`define TOUCH_BURST_QUALIFIER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TBQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TBQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tbq_pkg.sv =====
package tbq_pkg;

  // burst and window geometry
  localparam int BURST_LEN    = 50;
  localparam int WINDOW_START = 30;
  localparam int WINDOW_LEN   = 15;

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int COORD_W  = 10;
  localparam int GAIN_W   = 16;
  localparam int MARGIN_W = 8;

  // burst counter and window index
  localparam int CNT_W  = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam int WIN_IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // window sum and reciprocal for the average
  localparam int LEN_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = SAMPLE_W + LEN_W;
  localparam int AVG_SH = SUM_W + LEN_W;
  localparam int AVG_K  = ((1 << AVG_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int AVG_KW = AVG_SH + 1;
  localparam int AVG_PW = SUM_W + AVG_KW;

  // gain product and divide by 10000
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int GAIN_DIV = 10000;
  localparam int DIV_W    = $clog2(GAIN_DIV + 1);
  localparam int QUO_W    = PROD_W - DIV_W + 1;

  // 10000 = 16 * 625: shift out the power of two, then reciprocal multiply for 625
  localparam int DIV_PRE = 4;
  localparam int DIV_ODD = GAIN_DIV >> DIV_PRE;
  localparam int PRE_W   = PROD_W - DIV_PRE;
  localparam int REC_SH  = PRE_W + $clog2(DIV_ODD);
  localparam int REC_K   = ((1 << REC_SH) + DIV_ODD - 1) / DIV_ODD;
  localparam int REC_W   = REC_SH - $clog2(DIV_ODD) + 1;
  localparam int REC_PW  = PRE_W + REC_W;

  // sequencer step counter
  localparam int STEP_W = $clog2(WINDOW_LEN + 1);

  // stream widths
  localparam int IN_DW  = 2 * SAMPLE_W;
  localparam int OUT_FW = 3 + 4 * COORD_W;
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  typedef logic [CFG_AW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MARGIN = 3'd0;
  localparam cfg_idx_t REG_X_REF  = 3'd1;
  localparam cfg_idx_t REG_Y_REF  = 3'd2;
  localparam cfg_idx_t REG_X_GAIN = 3'd3;
  localparam cfg_idx_t REG_Y_GAIN = 3'd4;
  localparam cfg_idx_t REG_X_LIM  = 3'd5;
  localparam cfg_idx_t REG_Y_LIM  = 3'd6;

  // register reset values
  localparam logic [MARGIN_W-1:0] RST_MARGIN = 8'd15;
  localparam logic [SAMPLE_W-1:0] RST_X_REF  = 8'd244;
  localparam logic [SAMPLE_W-1:0] RST_Y_REF  = 8'd231;
  localparam logic [GAIN_W-1:0]   RST_X_GAIN = 16'd22641;
  localparam logic [GAIN_W-1:0]   RST_Y_GAIN = 16'd13203;
  localparam logic [COORD_W-1:0]  RST_X_LIM  = 10'd479;
  localparam logic [COORD_W-1:0]  RST_Y_LIM  = 10'd271;

  // controller to datapath commands
  typedef struct packed {
    logic              step;
    logic              scan;
    logic [STEP_W-1:0] idx;
    logic              calc_avg;
    logic              calc_mul;
    logic              div_step;
    logic              commit;
    logic              load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic burst_end;
  } status_t;

  // one result word
  typedef struct packed {
    logic               press_accepted;
    logic               is_pressed;
    logic               release_seen;
    logic [COORD_W-1:0] press_x;
    logic [COORD_W-1:0] press_y;
    logic [COORD_W-1:0] release_x;
    logic [COORD_W-1:0] release_y;
  } out_word_t;

endpackage

// ===== sv/tbq_div.sv =====
module tbq_div (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [tbq_pkg::PROD_W-1:0] dividend,
  output logic [tbq_pkg::QUO_W-1:0]  quo
);

  logic [tbq_pkg::PRE_W-1:0]  prod_r;
  logic [tbq_pkg::QUO_W-1:0]  quo_r;
  logic [tbq_pkg::REC_PW-1:0] rec_p;

  // reciprocal multiply for the odd part of the divisor
  assign rec_p = tbq_pkg::REC_PW'(prod_r) * tbq_pkg::REC_PW'(tbq_pkg::REC_K);

  // product latched with the power of two shifted out, quotient registered on step
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= dividend[tbq_pkg::PROD_W-1:tbq_pkg::DIV_PRE];
    end
    if (step) begin
      quo_r <= rec_p[tbq_pkg::REC_SH +: tbq_pkg::QUO_W];
    end
  end

  assign quo = quo_r;

endmodule

// ===== sv/tbq_dp.sv =====
module tbq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [tbq_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [tbq_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          touched,
  input  logic [tbq_pkg::SAMPLE_W-1:0]  sample_x,
  input  logic [tbq_pkg::SAMPLE_W-1:0]  sample_y,
  input  tbq_pkg::cmd_t                 cmd,
  output tbq_pkg::status_t              status,
  output tbq_pkg::out_word_t            out_word
);

  // configuration registers
  logic [tbq_pkg::MARGIN_W-1:0] margin_r;
  logic [tbq_pkg::SAMPLE_W-1:0] x_ref_r, y_ref_r;
  logic [tbq_pkg::GAIN_W-1:0]   x_gain_r, y_gain_r;
  logic [tbq_pkg::COORD_W-1:0]  x_lim_r, y_lim_r;

  // filter state
  logic [tbq_pkg::CNT_W-1:0]    count_r;
  logic [tbq_pkg::SAMPLE_W-1:0] win_x_r [tbq_pkg::WINDOW_LEN];
  logic [tbq_pkg::SAMPLE_W-1:0] win_y_r [tbq_pkg::WINDOW_LEN];
  logic                         pressed_r, released_r, accepted_r;
  logic [tbq_pkg::COORD_W-1:0]  down_x_r, down_y_r, up_x_r, up_y_r;

  // burst-end working registers
  logic [tbq_pkg::SUM_W-1:0]    sum_x_r, sum_y_r;
  logic [tbq_pkg::SAMPLE_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [tbq_pkg::SAMPLE_W-1:0] avg_x_r, avg_y_r;
  logic                         stable_r;
  tbq_pkg::out_word_t           out_r;

  logic                         take;
  logic                         in_win;
  logic [tbq_pkg::WIN_IW-1:0]   wr_idx;
  logic [tbq_pkg::CNT_W-1:0]    count_inc;
  logic [tbq_pkg::WIN_IW-1:0]   rd_idx;
  logic [tbq_pkg::SAMPLE_W-1:0] rd_x, rd_y;
  logic [tbq_pkg::AVG_PW-1:0]   avg_px, avg_py;
  logic [tbq_pkg::SAMPLE_W-1:0] dist_x, dist_y;
  logic [tbq_pkg::PROD_W-1:0]   prod_x, prod_y;
  logic [tbq_pkg::QUO_W-1:0]    quo_x, quo_y;
  logic [tbq_pkg::COORD_W-1:0]  sat_x, sat_y;

  // sample acceptance and window slot
  always_comb begin
    int off;
    int inc;
    off       = int'(count_r) - tbq_pkg::WINDOW_START;
    inc       = int'(count_r) + 1;
    take      = touched && (int'(count_r) < tbq_pkg::BURST_LEN);
    in_win    = (off >= 0) && (off < tbq_pkg::WINDOW_LEN);
    wr_idx    = off[tbq_pkg::WIN_IW-1:0];
    count_inc = (inc >= tbq_pkg::BURST_LEN) ? '0 : inc[tbq_pkg::CNT_W-1:0];
  end

  assign status.burst_end = take && (int'(count_r) == tbq_pkg::BURST_LEN - 1);

  // window read for the scan
  assign rd_idx = cmd.idx[tbq_pkg::WIN_IW-1:0];
  assign rd_x   = win_x_r[rd_idx];
  assign rd_y   = win_y_r[rd_idx];

  // average by reciprocal multiply
  assign avg_px = tbq_pkg::AVG_PW'(sum_x_r) * tbq_pkg::AVG_PW'(tbq_pkg::AVG_K);
  assign avg_py = tbq_pkg::AVG_PW'(sum_y_r) * tbq_pkg::AVG_PW'(tbq_pkg::AVG_K);

  // distance from reference times gain
  assign dist_x = (x_ref_r >= avg_x_r) ? (x_ref_r - avg_x_r) : (avg_x_r - x_ref_r);
  assign dist_y = (y_ref_r >= avg_y_r) ? (y_ref_r - avg_y_r) : (avg_y_r - y_ref_r);
  assign prod_x = tbq_pkg::PROD_W'(dist_x) * tbq_pkg::PROD_W'(x_gain_r);
  assign prod_y = tbq_pkg::PROD_W'(dist_y) * tbq_pkg::PROD_W'(y_gain_r);

  tbq_div u_div_x (
    .clk      (clk),
    .load     (cmd.calc_mul),
    .step     (cmd.div_step),
    .dividend (prod_x),
    .quo      (quo_x)
  );

  tbq_div u_div_y (
    .clk      (clk),
    .load     (cmd.calc_mul),
    .step     (cmd.div_step),
    .dividend (prod_y),
    .quo      (quo_y)
  );

  // clamp at the screen limits
  assign sat_x = (tbq_pkg::QUO_W'(x_lim_r) < quo_x) ? x_lim_r : tbq_pkg::COORD_W'(quo_x);
  assign sat_y = (tbq_pkg::QUO_W'(y_lim_r) < quo_y) ? y_lim_r : tbq_pkg::COORD_W'(quo_y);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= tbq_pkg::RST_MARGIN;
      x_ref_r  <= tbq_pkg::RST_X_REF;
      y_ref_r  <= tbq_pkg::RST_Y_REF;
      x_gain_r <= tbq_pkg::RST_X_GAIN;
      y_gain_r <= tbq_pkg::RST_Y_GAIN;
      x_lim_r  <= tbq_pkg::RST_X_LIM;
      y_lim_r  <= tbq_pkg::RST_Y_LIM;
    end else if (cfg_valid) begin
      case (cfg_addr)
        tbq_pkg::REG_MARGIN: margin_r <= cfg_data[tbq_pkg::MARGIN_W-1:0];
        tbq_pkg::REG_X_REF:  x_ref_r  <= cfg_data[tbq_pkg::SAMPLE_W-1:0];
        tbq_pkg::REG_Y_REF:  y_ref_r  <= cfg_data[tbq_pkg::SAMPLE_W-1:0];
        tbq_pkg::REG_X_GAIN: x_gain_r <= cfg_data[tbq_pkg::GAIN_W-1:0];
        tbq_pkg::REG_Y_GAIN: y_gain_r <= cfg_data[tbq_pkg::GAIN_W-1:0];
        tbq_pkg::REG_X_LIM:  x_lim_r  <= cfg_data[tbq_pkg::COORD_W-1:0];
        tbq_pkg::REG_Y_LIM:  y_lim_r  <= cfg_data[tbq_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // poll update, release and press commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pressed_r  <= 1'b0;
      released_r <= 1'b0;
      accepted_r <= 1'b0;
      down_x_r   <= '0;
      down_y_r   <= '0;
      up_x_r     <= '0;
      up_y_r     <= '0;
      for (int i = 0; i < tbq_pkg::WINDOW_LEN; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else if (cmd.step) begin
      accepted_r <= 1'b0;
      if (take) begin
        count_r <= count_inc;
        if (in_win) begin
          win_x_r[wr_idx] <= sample_x;
          win_y_r[wr_idx] <= sample_y;
        end
      end else if (pressed_r) begin
        pressed_r  <= 1'b0;
        released_r <= 1'b1;
        up_x_r     <= down_x_r;
        up_y_r     <= down_y_r;
        down_x_r   <= '0;
        down_y_r   <= '0;
        for (int i = 0; i < tbq_pkg::WINDOW_LEN; i++) begin
          win_x_r[i] <= '0;
          win_y_r[i] <= '0;
        end
      end
    end else if (cmd.commit && stable_r) begin
      accepted_r <= 1'b1;
      pressed_r  <= 1'b1;
      down_x_r   <= sat_x;
      down_y_r   <= sat_y;
      up_x_r     <= '0;
      up_y_r     <= '0;
    end
  end

  // window scan, average and stability
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (cmd.idx == '0) begin
        sum_x_r <= tbq_pkg::SUM_W'(rd_x);
        sum_y_r <= tbq_pkg::SUM_W'(rd_y);
        min_x_r <= rd_x;
        max_x_r <= rd_x;
        min_y_r <= rd_y;
        max_y_r <= rd_y;
      end else begin
        sum_x_r <= sum_x_r + tbq_pkg::SUM_W'(rd_x);
        sum_y_r <= sum_y_r + tbq_pkg::SUM_W'(rd_y);
        if (rd_x < min_x_r) min_x_r <= rd_x;
        if (rd_x > max_x_r) max_x_r <= rd_x;
        if (rd_y < min_y_r) min_y_r <= rd_y;
        if (rd_y > max_y_r) max_y_r <= rd_y;
      end
    end
    if (cmd.calc_avg) begin
      avg_x_r  <= avg_px[tbq_pkg::AVG_SH +: tbq_pkg::SAMPLE_W];
      avg_y_r  <= avg_py[tbq_pkg::AVG_SH +: tbq_pkg::SAMPLE_W];
      stable_r <= ((max_x_r - min_x_r) < margin_r) && ((max_y_r - min_y_r) < margin_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.press_accepted <= accepted_r;
      out_r.is_pressed     <= pressed_r;
      out_r.release_seen   <= released_r;
      out_r.press_x        <= down_x_r;
      out_r.press_y        <= down_y_r;
      out_r.release_x      <= up_x_r;
      out_r.release_y      <= up_y_r;
    end
  end

  assign out_word = out_r;

endmodule

// ===== sv/tbq_ctrl.sv =====
module tbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tbq_pkg::status_t  status,
  output tbq_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_PUSH
  } state_t;

  state_t                     state_r;
  logic [tbq_pkg::STEP_W-1:0] cnt_r;
  logic                       out_valid_r;
  logic                       in_fire;
  logic                       load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign load       = (state_r == ST_PUSH) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.step     = in_fire;
    cmd.scan     = (state_r == ST_SCAN);
    cmd.idx      = cnt_r;
    cmd.calc_avg = (state_r == ST_AVG);
    cmd.calc_mul = (state_r == ST_MUL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.commit   = (state_r == ST_COMMIT);
    cmd.load_out = load;
  end

  // sequencer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_fire) begin
            state_r <= status.burst_end ? ST_SCAN : ST_PUSH;
          end
        end
        ST_SCAN: begin
          if (cnt_r == tbq_pkg::STEP_W'(tbq_pkg::WINDOW_LEN - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_AVG;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_AVG: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/touch_burst_qualifier.sv =====
// Touch burst qualifier: takes one poll word per handshake (touch flag on in_tuser, raw X and
// Y samples on in_tdata) and returns exactly one result word per poll with the press/release
// flags and the screen coordinates. An ordinary poll goes straight to the output load; the
// poll that closes a burst first runs the window scan, which reads one stored entry per cycle,
// then the average, the gain product, the divide by 10000 (a shift and a reciprocal multiply),
// the commit and the output load, which waits until the output register is free.
// The input is taken again as soon as the result is placed in the output register, even if
// the previous word there has been handed over in the same cycle. Configuration writes are
// always ready and should only be issued while no poll is in flight.
`include "touch_burst_qualifier_assert.svh"

module touch_burst_qualifier (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: sample_x, sample_y
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tbq_pkg::IN_DW-1:0]    in_tdata,
  // in_tuser: touched
  input  logic                         in_tuser,
  // out_tdata: press_accepted, is_pressed, release_seen, press_x, press_y,
  // release_x, release_y, zero fill
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tbq_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tbq_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [tbq_pkg::CFG_DW-1:0]   cfg_data
);

  tbq_pkg::cmd_t      cmd;
  tbq_pkg::status_t   status;
  tbq_pkg::out_word_t out_word;

  assign cfg_ready = 1'b1;

  tbq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tbq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .touched   (in_tuser),
    .sample_x  (in_tdata[tbq_pkg::SAMPLE_W-1:0]),
    .sample_y  (in_tdata[2*tbq_pkg::SAMPLE_W-1:tbq_pkg::SAMPLE_W]),
    .cmd       (cmd),
    .status    (status),
    .out_word  (out_word)
  );

  // result word packed from the lowest bit up
  assign out_tdata = tbq_pkg::OUT_DW'({out_word.release_y, out_word.release_x,
                                       out_word.press_y, out_word.press_x,
                                       out_word.release_seen, out_word.is_pressed,
                                       out_word.press_accepted});

  `TBQ_ASSERT_NXT(a_busy_after_poll, in_tvalid && in_tready, !in_tready, "poll accepted twice in a row")
  `TBQ_ASSERT_IMP(a_accept_sets_press, out_tvalid && out_word.press_accepted, out_word.is_pressed, "accepted press without pressed flag")
  `TBQ_ASSERT_IMP(a_pressed_no_release, out_tvalid && out_word.is_pressed, (out_word.release_x == '0) && (out_word.release_y == '0), "release coordinates kept while pressed")
  `TBQ_ASSERT_IMP(a_idle_no_press, out_tvalid && !out_word.is_pressed, (out_word.press_x == '0) && (out_word.press_y == '0), "press coordinates kept while not pressed")

endmodule
